/* src/rvdec_pkg.sv */
`timescale 1ns / 1ps

package rvdec_pkg;

  localparam int unsigned XLEN = 32;
  localparam int unsigned ACT_W = 4;
  localparam int unsigned OP_W = 6;
  localparam int unsigned REG_W = 5;

  typedef enum logic [ACT_W-1:0] {
    ACT_R      = 4'd0,
    ACT_I_ALU  = 4'd1,
    ACT_LOAD   = 4'd2,
    ACT_JALR   = 4'd3,
    ACT_SYSTEM = 4'd4,
    ACT_STORE  = 4'd5,
    ACT_BRANCH = 4'd6,
    ACT_LUI    = 4'd7,
    ACT_AUIPC  = 4'd8,
    ACT_JAL    = 4'd9
  } action_e;

  typedef enum logic [OP_W-1:0] {
    OP_NONE   = 6'd0,
    OP_ADD    = 6'd1,
    OP_XOR    = 6'd2,
    OP_OR     = 6'd3,
    OP_AND    = 6'd4,
    OP_SLL    = 6'd5,
    OP_SRL    = 6'd6,
    OP_SLT    = 6'd7,
    OP_SLTU   = 6'd8,
    OP_SUB    = 6'd9,
    OP_SRA    = 6'd10,
    OP_ADDI   = 6'd11,
    OP_XORI   = 6'd12,
    OP_ORI    = 6'd13,
    OP_ANDI   = 6'd14,
    OP_SLLI   = 6'd15,
    OP_SRLI   = 6'd16,
    OP_SRAI   = 6'd17,
    OP_SLTI   = 6'd18,
    OP_SLTIU  = 6'd19,
    OP_LB     = 6'd20,
    OP_LH     = 6'd21,
    OP_LW     = 6'd22,
    OP_LBU    = 6'd23,
    OP_LHU    = 6'd24,
    OP_JALR   = 6'd25,
    OP_ECALL  = 6'd26,
    OP_EBREAK = 6'd27,
    OP_SB     = 6'd28,
    OP_SH     = 6'd29,
    OP_SW     = 6'd30,
    OP_BEQ    = 6'd31,
    OP_BNE    = 6'd32,
    OP_BLT    = 6'd33,
    OP_BGE    = 6'd34,
    OP_BLTU   = 6'd35,
    OP_BGEU   = 6'd36,
    OP_LUI    = 6'd37,
    OP_AUIPC  = 6'd38,
    OP_JAL    = 6'd39
  } op_e;

  localparam op_e OP_LAST = OP_JAL;

  typedef struct packed {
    logic [XLEN-1:0]  instruction;
    logic [ACT_W-1:0] action;
  } instr_t;

  typedef struct packed {
    logic [OP_W-1:0]         operation;
    logic [REG_W-1:0]        dest_reg;
    logic [REG_W-1:0]        src1_reg;
    logic [REG_W-1:0]        src2_reg;
    logic signed [XLEN-1:0]  immediate;
  } dec_t;

  function automatic op_e r_plain_op(input logic [2:0] f3);
    op_e op;
    unique case (f3)
      3'd0: op = OP_ADD;
      3'd1: op = OP_SLL;
      3'd2: op = OP_SLT;
      3'd3: op = OP_SLTU;
      3'd4: op = OP_XOR;
      3'd5: op = OP_SRL;
      3'd6: op = OP_OR;
      3'd7: op = OP_AND;
      default: op = OP_NONE;
    endcase
    return op;
  endfunction

  function automatic op_e i_alu_op(input logic [2:0] f3);
    op_e op;
    unique case (f3)
      3'd0: op = OP_ADDI;
      3'd1: op = OP_SLLI;
      3'd2: op = OP_SLTI;
      3'd3: op = OP_SLTIU;
      3'd4: op = OP_XORI;
      3'd5: op = OP_SRLI;
      3'd6: op = OP_ORI;
      3'd7: op = OP_ANDI;
      default: op = OP_NONE;
    endcase
    return op;
  endfunction

  function automatic op_e load_op(input logic [2:0] f3);
    op_e op;
    unique case (f3)
      3'd0: op = OP_LB;
      3'd1: op = OP_LH;
      3'd2: op = OP_LW;
      3'd4: op = OP_LBU;
      3'd5: op = OP_LHU;
      default: op = OP_NONE;
    endcase
    return op;
  endfunction

  function automatic op_e branch_op(input logic [2:0] f3);
    op_e op;
    unique case (f3)
      3'd0: op = OP_BEQ;
      3'd1: op = OP_BNE;
      3'd4: op = OP_BLT;
      3'd5: op = OP_BGE;
      3'd6: op = OP_BLTU;
      3'd7: op = OP_BGEU;
      default: op = OP_NONE;
    endcase
    return op;
  endfunction

endpackage

/* src/rvdec_stage.sv */
`timescale 1ns / 1ps

module rvdec_stage #(
  parameter type payload_t = logic
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     up_valid,
  output logic     up_ready,
  input  payload_t up_data,
  output logic     down_valid,
  input  logic     down_ready,
  output payload_t down_data
);

  logic     valid;
  payload_t data;

  assign up_ready   = !valid || down_ready;
  assign down_valid = valid;
  assign down_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data <= up_data;
    end
  end

endmodule

/* src/rvdec_decode.sv */
`timescale 1ns / 1ps

module rvdec_decode
  import rvdec_pkg::*;
(
  input  instr_t instr,
  output dec_t   dec
);

  logic [XLEN-1:0]  ir;
  logic [REG_W-1:0] rd;
  logic [2:0]       f3;
  logic [REG_W-1:0] rs1;
  logic [REG_W-1:0] rs2;
  logic [6:0]       f7;
  logic [XLEN-1:0]  imm_i;
  logic [XLEN-1:0]  imm_s;
  logic [XLEN-1:0]  imm_b;
  logic [XLEN-1:0]  imm_u;
  logic [XLEN-1:0]  imm_j;

  assign ir  = instr.instruction;
  assign rd  = ir[11:7];
  assign f3  = ir[14:12];
  assign rs1 = ir[19:15];
  assign rs2 = ir[24:20];
  assign f7  = ir[31:25];

  assign imm_i = {{20{ir[31]}}, ir[31:20]};
  assign imm_s = {{20{ir[31]}}, ir[31:25], ir[11:7]};
  assign imm_b = {{20{ir[31]}}, ir[7], ir[30:25], ir[11:8], 1'b0};
  assign imm_u = {12'd0, ir[31:12]};
  assign imm_j = {{12{ir[31]}}, ir[19:12], ir[20], ir[30:21], 1'b0};

  always_comb begin
    dec = '0;
    unique case (instr.action)
      ACT_R: begin
        dec.dest_reg = rd;
        dec.src1_reg = rs1;
        dec.src2_reg = rs2;
        if (f7 == 7'd0) begin
          dec.operation = r_plain_op(f3);
        end else if (f3 == 3'd0) begin
          dec.operation = OP_SUB;
        end else if (f3 == 3'd5) begin
          dec.operation = OP_SRA;
        end else begin
          dec.operation = OP_NONE;
        end
      end
      ACT_I_ALU: begin
        dec.dest_reg  = rd;
        dec.src1_reg  = rs1;
        dec.immediate = imm_i;
        if (f3 == 3'd5 && f7 != 7'd0) begin
          dec.operation = OP_SRAI;
        end else begin
          dec.operation = i_alu_op(f3);
        end
      end
      ACT_LOAD: begin
        dec.dest_reg  = rd;
        dec.src1_reg  = rs1;
        dec.immediate = imm_i;
        dec.operation = load_op(f3);
      end
      ACT_JALR: begin
        dec.dest_reg  = rd;
        dec.src1_reg  = rs1;
        dec.immediate = imm_i;
        dec.operation = OP_JALR;
      end
      ACT_SYSTEM: begin
        dec.dest_reg  = rd;
        dec.src1_reg  = rs1;
        dec.immediate = imm_i;
        dec.operation = (ir[31:20] == 12'd0) ? OP_ECALL : OP_EBREAK;
      end
      ACT_STORE: begin
        dec.src1_reg  = rs1;
        dec.src2_reg  = rs2;
        dec.immediate = imm_s;
        unique case (f3)
          3'd0:    dec.operation = OP_SB;
          3'd1:    dec.operation = OP_SH;
          default: dec.operation = OP_SW;
        endcase
      end
      ACT_BRANCH: begin
        dec.src1_reg  = rs1;
        dec.src2_reg  = rs2;
        dec.immediate = imm_b;
        dec.operation = branch_op(f3);
      end
      ACT_LUI: begin
        dec.dest_reg  = rd;
        dec.immediate = imm_u;
        dec.operation = OP_LUI;
      end
      ACT_AUIPC: begin
        dec.dest_reg  = rd;
        dec.immediate = imm_u;
        dec.operation = OP_AUIPC;
      end
      ACT_JAL: begin
        dec.dest_reg  = rd;
        dec.immediate = imm_j;
        dec.operation = OP_JAL;
      end
      default: begin
        dec = '0;
      end
    endcase
  end

endmodule

/* src/rv32i_instruction_decoder_top.sv */
`timescale 1ns / 1ps

// Channel   Ports                                Payload
// -------   ----------------------------------   -------------------------------
// input     instr_valid, instr_ready, instr      instr_t: instruction, action
// output    dec_valid, dec_ready, dec            dec_t: operation, regs, immediate
//
// One transaction is accepted per cycle while the output takes its results; a result
// passes the input register, the decode logic and the result register before it is
// shown.
// Reset clears both stage valid bits, so no result is shown after reset.
// A stall on the output propagates back through each stage's ready, and a
// stage refills in the same cycle its content is taken.

module rv32i_instruction_decoder_top
  import rvdec_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   instr_valid,
  output logic   instr_ready,
  input  instr_t instr,
  output logic   dec_valid,
  input  logic   dec_ready,
  output dec_t   dec
);

  logic   mid_valid;
  logic   mid_ready;
  instr_t mid_instr;
  dec_t   mid_dec;

  rvdec_stage #(
    .payload_t(instr_t)
  ) u_in_stage (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (instr_valid),
    .up_ready  (instr_ready),
    .up_data   (instr),
    .down_valid(mid_valid),
    .down_ready(mid_ready),
    .down_data (mid_instr)
  );

  rvdec_decode u_decode (
    .instr(mid_instr),
    .dec  (mid_dec)
  );

  rvdec_stage #(
    .payload_t(dec_t)
  ) u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (mid_valid),
    .up_ready  (mid_ready),
    .up_data   (mid_dec),
    .down_valid(dec_valid),
    .down_ready(dec_ready),
    .down_data (dec)
  );

endmodule

/* src/rvdec_checker.sv */
`timescale 1ns / 1ps

module rvdec_checker
  import rvdec_pkg::*;
(
  input logic   clk,
  input logic   rst,
  input logic   instr_ready,
  input logic   dec_valid,
  input logic   dec_ready,
  input dec_t   dec
);

  // No result may be shown in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !dec_valid)
    else $error("result valid after reset");

  // A stalled result transaction holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    dec_valid && !dec_ready |=> dec_valid && $stable(dec))
    else $error("stalled result changed");

  // With the result register empty, the pipeline must take new input.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !dec_valid |-> instr_ready)
    else $error("input blocked with empty output");

  // Operation numbers stay in the defined range.
  a_op_range: assert property (@(posedge clk) disable iff (rst)
    dec_valid |-> dec.operation <= OP_LAST)
    else $error("operation out of range");

  // Upper-immediate and jump formats carry no source registers.
  a_no_src: assert property (@(posedge clk) disable iff (rst)
    dec_valid && (dec.operation == OP_LUI || dec.operation == OP_AUIPC ||
                  dec.operation == OP_JAL)
    |-> dec.src1_reg == '0 && dec.src2_reg == '0)
    else $error("source register set for U or J format");

endmodule

bind rv32i_instruction_decoder_top rvdec_checker u_rvdec_checker (
  .clk        (clk),
  .rst        (rst),
  .instr_ready(instr_ready),
  .dec_valid  (dec_valid),
  .dec_ready  (dec_ready),
  .dec        (dec)
);

/* tb/sv/tb_rv32i_instruction_decoder_top.sv */
`timescale 1ns / 1ps

module tb_rv32i_instruction_decoder_top;
  import rvdec_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;

  logic   clk;
  logic   rst;
  logic   instr_valid;
  logic   instr_ready;
  instr_t instr;
  logic   dec_valid;
  logic   dec_ready;
  dec_t   dec;

  dec_t        expected_dec[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit          idle_en;
  int          ready_hold = 0;

  rv32i_instruction_decoder_top dut (
    .clk         (clk),
    .rst         (rst),
    .instr_valid (instr_valid),
    .instr_ready (instr_ready),
    .instr       (instr),
    .dec_valid   (dec_valid),
    .dec_ready   (dec_ready),
    .dec         (dec)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic dec_t decode_expect(instr_t it);
    logic [31:0] w;
    logic [2:0]  f3;
    logic [6:0]  f7;
    op_e         op;
    dec_t        d;
    w  = it.instruction;
    f3 = w[14:12];
    f7 = w[31:25];
    op = OP_NONE;
    d  = '0;
    case (it.action)
      ACT_R: begin
        d.dest_reg = w[11:7];
        d.src1_reg = w[19:15];
        d.src2_reg = w[24:20];
        if (f7 == 7'd0) begin
          case (f3)
            3'd0: op = OP_ADD;
            3'd1: op = OP_SLL;
            3'd2: op = OP_SLT;
            3'd3: op = OP_SLTU;
            3'd4: op = OP_XOR;
            3'd5: op = OP_SRL;
            3'd6: op = OP_OR;
            default: op = OP_AND;
          endcase
        end else if (f3 == 3'd0) begin
          op = OP_SUB;
        end else if (f3 == 3'd5) begin
          op = OP_SRA;
        end
      end
      ACT_I_ALU, ACT_LOAD, ACT_JALR, ACT_SYSTEM: begin
        d.dest_reg  = w[11:7];
        d.src1_reg  = w[19:15];
        d.immediate = {{20{w[31]}}, w[31:20]};
        case (it.action)
          ACT_I_ALU: begin
            case (f3)
              3'd0: op = OP_ADDI;
              3'd1: op = OP_SLLI;
              3'd2: op = OP_SLTI;
              3'd3: op = OP_SLTIU;
              3'd4: op = OP_XORI;
              3'd5: op = (f7 != 7'd0) ? OP_SRAI : OP_SRLI;
              3'd6: op = OP_ORI;
              default: op = OP_ANDI;
            endcase
          end
          ACT_LOAD: begin
            case (f3)
              3'd0: op = OP_LB;
              3'd1: op = OP_LH;
              3'd2: op = OP_LW;
              3'd4: op = OP_LBU;
              3'd5: op = OP_LHU;
              default: op = OP_NONE;
            endcase
          end
          ACT_JALR: op = OP_JALR;
          default: op = (d.immediate == 32'd0) ? OP_ECALL : OP_EBREAK;
        endcase
      end
      ACT_STORE: begin
        d.src1_reg  = w[19:15];
        d.src2_reg  = w[24:20];
        d.immediate = {{20{w[31]}}, w[31:25], w[11:7]};
        op = (f3 == 3'd0) ? OP_SB : (f3 == 3'd1) ? OP_SH : OP_SW;
      end
      ACT_BRANCH: begin
        d.src1_reg  = w[19:15];
        d.src2_reg  = w[24:20];
        d.immediate = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
        case (f3)
          3'd0: op = OP_BEQ;
          3'd1: op = OP_BNE;
          3'd4: op = OP_BLT;
          3'd5: op = OP_BGE;
          3'd6: op = OP_BLTU;
          3'd7: op = OP_BGEU;
          default: op = OP_NONE;
        endcase
      end
      ACT_LUI, ACT_AUIPC: begin
        d.dest_reg  = w[11:7];
        d.immediate = {12'd0, w[31:12]};
        op = (it.action == ACT_LUI) ? OP_LUI : OP_AUIPC;
      end
      ACT_JAL: begin
        d.dest_reg  = w[11:7];
        d.immediate = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
        op = OP_JAL;
      end
      default: begin
      end
    endcase
    d.operation = op;
    return d;
  endfunction

  task automatic send_instr(input logic [31:0] word, input logic [3:0] act);
    int     gap;
    instr_t it;
    it.instruction = word;
    it.action      = act;
    gap = idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      instr_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    instr_valid <= 1'b1;
    instr       <= it;
    do @(negedge clk); while (!instr_ready);
    expected_dec.push_back(decode_expect(it));
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      dec_ready <= 1'b0;
    end else if (ready_hold > 0) begin
      ready_hold = ready_hold - 1;
      dec_ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 3) == 0) begin
      ready_hold = pick_gap();
      dec_ready <= 1'b0;
    end else begin
      dec_ready <= 1'b1;
    end
  end

  always @(negedge clk) begin
    dec_t exp_d;
    if (!rst && dec_valid && dec_ready) begin
      if (expected_dec.size() == 0) begin
        $error("unexpected result transaction: %h", dec);
        mismatches++;
      end else begin
        exp_d = expected_dec.pop_front();
        if (dec.operation !== exp_d.operation) begin
          $error("operation: expected %0d, actual %0d", exp_d.operation, dec.operation);
          mismatches++;
        end
        if (dec.dest_reg !== exp_d.dest_reg) begin
          $error("dest_reg: expected %0d, actual %0d", exp_d.dest_reg, dec.dest_reg);
          mismatches++;
        end
        if (dec.src1_reg !== exp_d.src1_reg) begin
          $error("src1_reg: expected %0d, actual %0d", exp_d.src1_reg, dec.src1_reg);
          mismatches++;
        end
        if (dec.src2_reg !== exp_d.src2_reg) begin
          $error("src2_reg: expected %0d, actual %0d", exp_d.src2_reg, dec.src2_reg);
          mismatches++;
        end
        if (dec.immediate !== exp_d.immediate) begin
          $error("immediate: expected %h, actual %h", exp_d.immediate, dec.immediate);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic test_field_extremes();
    send_instr(32'h0000_0000, ACT_SYSTEM);
    send_instr(32'hFFFF_FFFF, ACT_SYSTEM);
    send_instr(32'hFFFF_FFFF, ACT_BRANCH);
    send_instr(32'hFFFF_FFFF, ACT_JAL);
    send_instr(32'hFFFF_FFFF, ACT_LUI);
    send_instr(32'h8000_0000, ACT_STORE);
  endtask

  task automatic test_funct7_select();
    send_instr({7'h20, 5'd3, 5'd2, 3'd0, 5'd1, 7'h33}, ACT_R);
    send_instr({7'h20, 5'd31, 5'd30, 3'd5, 5'd29, 7'h33}, ACT_R);
    send_instr({7'h01, 5'd4, 5'd5, 3'd1, 5'd6, 7'h33}, ACT_R);
    send_instr({7'h20, 5'd7, 5'd8, 3'd5, 5'd9, 7'h13}, ACT_I_ALU);
    send_instr({7'h7F, 5'd10, 5'd11, 3'd1, 5'd12, 7'h13}, ACT_I_ALU);
  endtask

  task automatic test_unknown_funct3();
    send_instr({12'h123, 5'd13, 3'd3, 5'd14, 7'h03}, ACT_LOAD);
    send_instr({7'h55, 5'd15, 5'd16, 3'd2, 5'd17, 7'h63}, ACT_BRANCH);
  endtask

  task automatic test_store_funct3();
    send_instr({7'h3F, 5'd18, 5'd19, 3'd0, 5'd20, 7'h23}, ACT_STORE);
    send_instr({7'h40, 5'd21, 5'd22, 3'd1, 5'd23, 7'h23}, ACT_STORE);
    send_instr({7'h12, 5'd24, 5'd25, 3'd7, 5'd26, 7'h23}, ACT_STORE);
  endtask

  task automatic test_action_out_of_range();
    send_instr(32'hFFFF_FFFF, 4'd10);
    send_instr(32'hFFFF_FFFF, 4'd15);
  endtask

  task automatic test_random_stream();
    logic [31:0] w;
    logic [3:0]  a;
    for (int i = 0; i < 1450; i++) begin
      if (i % 100 == 0) idle_en = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 99) < 92) a = 4'($urandom_range(0, 9));
      else a = 4'($urandom_range(10, 15));
      w = $urandom;
      if ((a == ACT_R || a == ACT_I_ALU) && $urandom_range(0, 3) != 0)
        w[31:25] = $urandom_range(0, 1) ? 7'h20 : 7'h00;
      if (a == ACT_SYSTEM && $urandom_range(0, 3) == 0) w[31:20] = '0;
      send_instr(w, a);
    end
    idle_en = 1'b1;
  endtask

  initial begin
    idle_en = 1'b1;
    rst         <= 1'b1;
    instr_valid <= 1'b0;
    instr       <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_field_extremes();
    test_funct7_select();
    test_unknown_funct3();
    test_store_funct3();
    test_action_out_of_range();
    test_random_stream();

    instr_valid <= 1'b0;
    while (expected_dec.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* rv32i_instruction_decoder_top.f */
src/rvdec_pkg.sv
src/rvdec_stage.sv
src/rvdec_decode.sv
src/rv32i_instruction_decoder_top.sv
src/rvdec_checker.sv
tb/sv/tb_rv32i_instruction_decoder_top.sv
